// ===== src/osa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osa_pkg: shared types and constants
// Widths, register indexes and the command/status bundles between the
// averager controller and its datapath.
// ----------------------------------------------------------------------------
package osa_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 34;
    localparam int DISCARD_W   = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // One quotient bit per divider step.
    localparam int DIV_STEPS   = SUM_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DISCARD_BITS = 2'd2;

    localparam logic [SAMPLE_W-1:0] AVG_MAX = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] AVG_MIN = 16'h8000;

    typedef struct packed {
        logic accumulate;
        logic clear_block;
        logic load_div;
        logic div_step;
        logic finish;
        logic set_zero;
        logic load_out;
    } osa_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic block_done;
        logic out_free;
    } osa_status_t;

endpackage

// ===== src/offset_sample_averager_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// offset_sample_averager_core: block averager with offset and decimation
// Averages offset-corrected samples over a configured block length and
// scales the mean down by a power of two with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on sample_valid/sample_ready; each request carries one
//   signed 16-bit sample. Results leave on result_valid/result_ready with
//   average and saturated. Registers are written on cfg_write with cfg_index
//   and cfg_data; they must be written only while the block is idle, which
//   the block itself does not enforce. A sample that does not close a block
//   is added to the sum. The closing sample starts a restoring divider that
//   produces one quotient bit per cycle over the 34-bit sum; the result is
//   then formatted and put in the output register; no sample is taken
//   meanwhile. With a block length of zero each sample yields a zero result.
//   The output register holds a finished result while the receiver stalls;
//   the next sample is still accepted, and only the next result waits for
//   the register to free up.
//   Reset clears the accumulator and sample counter and loads a block length
//   of 1, offset 0 and a discard shift of 8.
// ----------------------------------------------------------------------------
module offset_sample_averager_core #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [osa_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [osa_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    input  logic signed [osa_pkg::SAMPLE_W-1:0]  sample,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic signed [osa_pkg::SAMPLE_W-1:0]  average,
    output logic                                 saturated
);

    osa_pkg::osa_cmd_t    cmd;
    osa_pkg::osa_status_t status;

    osa_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .status       (status),
        .cmd          (cmd)
    );

    osa_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .average      (average),
        .saturated    (saturated)
    );

endmodule

// ===== src/osa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osa_ctrl: averager controller
// Sequences sample intake, the bit-serial division, result formatting and
// the hand-off into the output register.
// ----------------------------------------------------------------------------
module osa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  osa_pkg::osa_status_t status,
    output osa_pkg::osa_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_POST = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [osa_pkg::STEP_W-1:0] LAST_STEP =
        osa_pkg::STEP_W'(osa_pkg::DIV_STEPS - 1);

    logic [2:0]                   state_reg;
    logic [2:0]                   state_next;
    logic [osa_pkg::STEP_W-1:0]   step_reg;
    logic [osa_pkg::STEP_W-1:0]   step_next;
    logic                         accept;

    assign sample_ready = (state_reg == S_IDLE);
    assign accept       = sample_valid && sample_ready;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (status.count_zero)
                    begin
                        cmd.clear_block = 1'b1;
                        cmd.set_zero    = 1'b1;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        cmd.accumulate = 1'b1;
                        if (status.block_done)
                        begin
                            state_next = S_LOAD;
                        end
                    end
                end
            end
            S_LOAD:
            begin
                cmd.load_div    = 1'b1;
                cmd.clear_block = 1'b1;
                step_next       = '0;
                state_next      = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

`ifndef ASSERT_OFF
    // The divider must run exactly its full number of steps before formatting.
    a_post_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POST) |-> ($past(state_reg) == S_DIV && $past(step_reg) == LAST_STEP))
        else $error("result formatting entered without a full division");
`endif

endmodule

// ===== src/osa_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osa_datapath: averager datapath
// Configuration registers, offset-corrected accumulator, restoring divider,
// power-of-two scaling with saturation, and the output register.
// ----------------------------------------------------------------------------
module osa_datapath #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [osa_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [osa_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic signed [osa_pkg::SAMPLE_W-1:0]  sample,
    input  osa_pkg::osa_cmd_t                    cmd,
    output osa_pkg::osa_status_t                 status,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic signed [osa_pkg::SAMPLE_W-1:0]  average,
    output logic                                 saturated
);

    localparam int SW = osa_pkg::SUM_W;
    localparam int DW = osa_pkg::SAMPLE_W;

    logic [COUNT_BITS-1:0]               count_reg;
    logic signed [DW-1:0]                offset_reg;
    logic [osa_pkg::DISCARD_W-1:0]       discard_reg;

    logic signed [SW-1:0]                sum_reg;
    logic signed [SW-1:0]                sum_next;
    logic [COUNT_BITS-1:0]               taken_reg;
    logic [COUNT_BITS-1:0]               taken_next;

    logic [COUNT_BITS-1:0]               divisor_reg;
    logic [COUNT_BITS-1:0]               rem_reg;
    logic [COUNT_BITS-1:0]               rem_next;
    logic [SW-1:0]                       quo_reg;
    logic [SW-1:0]                       quo_next;
    logic                                neg_reg;

    logic [DW-1:0]                       res_avg_reg;
    logic [DW-1:0]                       res_avg_next;
    logic                                res_sat_reg;
    logic                                res_sat_next;

    logic [DW-1:0]                       out_avg_reg;
    logic                                out_sat_reg;
    logic                                out_valid_reg;

    logic signed [DW:0]                  diff;
    logic [COUNT_BITS-1:0]               taken_inc;
    logic [COUNT_BITS:0]                 trial;
    logic [COUNT_BITS:0]                 shifted_rem;
    logic [SW-1:0]                       sum_mag;
    logic [SW-1:0]                       scaled;

    // Accumulation path.
    assign diff      = {sample[DW-1], sample} - {offset_reg[DW-1], offset_reg};
    assign taken_inc = taken_reg + 1'b1;
    assign sum_next  = sum_reg + SW'(diff);

    assign status.count_zero = (count_reg == '0);
    // A wrapped counter means the block reached its full length.
    assign status.block_done = (taken_inc >= count_reg) || (taken_inc == '0);
    assign status.out_free   = !out_valid_reg || result_ready;

    assign sum_mag = sum_reg[SW-1] ? (SW'(0) - sum_reg) : sum_reg;

    // One restoring division step on the magnitude of the sum.
    assign shifted_rem = {rem_reg, quo_reg[SW-1]};
    assign trial       = shifted_rem - {1'b0, divisor_reg};

    always_comb
    begin
        if (shifted_rem >= {1'b0, divisor_reg})
        begin
            rem_next = trial[COUNT_BITS-1:0];
            quo_next = {quo_reg[SW-2:0], 1'b1};
        end
        else
        begin
            rem_next = shifted_rem[COUNT_BITS-1:0];
            quo_next = {quo_reg[SW-2:0], 1'b0};
        end
    end

    // Truncation toward zero twice in a row equals one truncation of the
    // magnitude by the combined divisor, so the shift works on the magnitude.
    assign scaled = quo_reg >> discard_reg;

    always_comb
    begin
        res_sat_next = 1'b0;
        if (neg_reg)
        begin
            if (scaled > SW'(32768))
            begin
                res_avg_next = osa_pkg::AVG_MIN;
                res_sat_next = 1'b1;
            end
            else
            begin
                res_avg_next = DW'(0) - scaled[DW-1:0];
            end
        end
        else
        begin
            if (scaled > SW'(32767))
            begin
                res_avg_next = osa_pkg::AVG_MAX;
                res_sat_next = 1'b1;
            end
            else
            begin
                res_avg_next = scaled[DW-1:0];
            end
        end
    end

    always_comb
    begin
        taken_next = taken_reg;
        if (cmd.clear_block)
        begin
            taken_next = '0;
        end
        else if (cmd.accumulate)
        begin
            taken_next = taken_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= COUNT_BITS'(1);
            offset_reg    <= '0;
            discard_reg   <= osa_pkg::DISCARD_W'(8);
            sum_reg       <= '0;
            taken_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    osa_pkg::REG_SAMPLE_COUNT: count_reg   <= cfg_data[COUNT_BITS-1:0];
                    osa_pkg::REG_OFFSET:       offset_reg  <= cfg_data;
                    osa_pkg::REG_DISCARD_BITS: discard_reg <= cfg_data[osa_pkg::DISCARD_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.clear_block)
            begin
                sum_reg <= '0;
            end
            else if (cmd.accumulate)
            begin
                sum_reg <= sum_next;
            end
            taken_reg <= taken_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_div)
        begin
            divisor_reg <= count_reg;
            rem_reg     <= '0;
            quo_reg     <= sum_mag;
            neg_reg     <= sum_reg[SW-1];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.set_zero)
        begin
            res_avg_reg <= '0;
            res_sat_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            res_avg_reg <= res_avg_next;
            res_sat_reg <= res_sat_next;
        end
        if (cmd.load_out)
        begin
            out_avg_reg <= res_avg_reg;
            out_sat_reg <= res_sat_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign average      = out_avg_reg;
    assign saturated    = out_sat_reg;

`ifndef ASSERT_OFF
    a_clear_empties_block: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_block |=> (sum_reg == '0 && taken_reg == '0))
        else $error("block state not cleared");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.div_step) |-> (rem_reg < divisor_reg))
        else $error("divider remainder reached the divisor");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && saturated) |->
            (average == osa_pkg::AVG_MAX || average == osa_pkg::AVG_MIN))
        else $error("saturated result not at a range limit");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |-> !cmd.load_out)
        else $error("pending result overwritten");
`endif

endmodule
